// ===== design/assert_macros.svh =====
// assertion macros shared by the nearest color search rtl
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ncm_pkg.sv =====
// shared types and constants of the nearest color search block
// no dependencies; used by the interfaces and every module
`default_nettype none

package ncm_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int MAX_SLOTS       = 256;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CHAN_W  = 8;
  localparam int INDEX_W = 8;
  localparam int FLOOR_W = 12;
  localparam int DIST_W  = 28;
  localparam int LFSR_W  = 16;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  localparam logic REG_RANDOM_FLOOR = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_DROP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [INDEX_W-1:0] idx;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  blue;
    logic               valid;
  } item_t;

endpackage

`default_nettype wire

// ===== design/ncm_if.sv =====
// request and result channel interfaces of the nearest color search block
// depends on ncm_pkg for field widths
`default_nettype none

interface ncm_in_if;
  import ncm_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [INDEX_W-1:0] entry_index;
  logic [CHAN_W-1:0]  entry_red;
  logic [CHAN_W-1:0]  entry_green;
  logic [CHAN_W-1:0]  entry_blue;
  logic               entry_valid;
  logic [CHAN_W-1:0]  target_red;
  logic [CHAN_W-1:0]  target_green;
  logic [CHAN_W-1:0]  target_blue;

  modport source (
    output valid, func, entry_index, entry_red, entry_green, entry_blue, entry_valid,
    output target_red, target_green, target_blue,
    input  ready
  );

  modport sink (
    input  valid, func, entry_index, entry_red, entry_green, entry_blue, entry_valid,
    input  target_red, target_green, target_blue,
    output ready
  );
endinterface

interface ncm_out_if;
  import ncm_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] best_index;
  logic               found;
  logic [DIST_W-1:0]  best_distance;

  modport source (
    output valid, best_index, found, best_distance,
    input  ready
  );

  modport sink (
    input  valid, best_index, found, best_distance,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/nearest_color_match_search_top.sv =====
// Nearest color search over a table of candidate colors.
// Requests arrive on in_ch (valid/ready). func=0 loads one table slot with a
// color and a usable mark; func=1 queries a target color. Each query gives one
// result on out_ch: the slot of the closest usable entry, found, and its Q8
// squared distance, with a fresh lfsr deviation below random_floor subtracted
// from every channel difference of each usable entry.
// A query walks the table one slot per cycle through the distance pipeline;
// the engine takes no new request until the result of the current query has
// entered the output register, and the color store has a single read port. A
// load is written into the table when the engine takes it from the queue and
// gives no result; loads to slots past the table are dropped.
// A two entry queue sits between intake and the engine, so requests are taken
// while a query runs and while a finished result waits in the output register.
// A stalled receiver holds the result; the engine waits with the next result
// until the register is free. Reset clears all usable marks,
// reseeds the lfsr and clears random_floor; the block is ready right after.
// random_floor is written over the apb-style port at byte address 0.
// depends on ncm_pkg, ncm_if, ncm_front, ncm_queue and ncm_back
`default_nettype none

module nearest_color_match_search_top #(
  parameter int TABLE_DEPTH = ncm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ncm_in_if.sink                     in_ch,
  ncm_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ncm_pkg::APB_AW-1:0] cfg_paddr,
  input  logic [ncm_pkg::APB_DW-1:0] cfg_pwdata,
  output logic [ncm_pkg::APB_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import ncm_pkg::*;

  logic [FLOOR_W-1:0] random_floor_r;
  logic               q_push_valid;
  logic               q_push_ready;
  item_t              q_push_item;
  logic               q_pop_valid;
  logic               q_pop_ready;
  item_t              q_pop_item;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_RANDOM_FLOOR) ?
                      {{(APB_DW - FLOOR_W){1'b0}}, random_floor_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      random_floor_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_RANDOM_FLOOR)) begin
      random_floor_r <= cfg_pwdata[FLOOR_W-1:0];
    end
  end

  ncm_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .in_ch   (in_ch),
    .q_valid (q_push_valid),
    .q_ready (q_push_ready),
    .q_item  (q_push_item)
  );

  ncm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  ncm_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .random_floor (random_floor_r),
    .pop_valid    (q_pop_valid),
    .pop_ready    (q_pop_ready),
    .pop_item     (q_pop_item),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

// ===== design/ncm_front.sv =====
// front end: takes requests and sorts them into load, query or dropped load
// depends on ncm_pkg and ncm_in_if; feeds ncm_queue
`default_nettype none

module ncm_front #(
  parameter int TABLE_DEPTH = ncm_pkg::TABLE_DEPTH_DEF
) (
  ncm_in_if.sink          in_ch,
  output logic            q_valid,
  input  logic            q_ready,
  output ncm_pkg::item_t  q_item
);
  import ncm_pkg::*;

  op_t op;

  always_comb begin
    if (in_ch.func) begin
      op = OP_QUERY;
    end else if (32'(in_ch.entry_index) < TABLE_DEPTH) begin
      op = OP_LOAD;
    end else begin
      op = OP_DROP;
    end
  end

  always_comb begin
    q_item.op    = op;
    q_item.idx   = in_ch.entry_index;
    q_item.valid = in_ch.entry_valid;
    if (in_ch.func) begin
      q_item.red   = in_ch.target_red;
      q_item.green = in_ch.target_green;
      q_item.blue  = in_ch.target_blue;
    end else begin
      q_item.red   = in_ch.entry_red;
      q_item.green = in_ch.entry_green;
      q_item.blue  = in_ch.entry_blue;
    end
  end

  // out of range loads are taken and discarded here
  assign in_ch.ready = q_ready;
  assign q_valid     = in_ch.valid && (op != OP_DROP);

endmodule

`default_nettype wire

// ===== design/ncm_queue.sv =====
// short request queue between the front end and the search engine
// depends on ncm_pkg for the request type and depth
`default_nettype none
`include "assert_macros.svh"

module ncm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  ncm_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output ncm_pkg::item_t  pop_item
);
  import ncm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slots_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
  `ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1, "push lost")
  `ASSERT_NEXT(a_count_down, clk, rst_n, pop && !push, count_r == $past(count_r) - 1'b1, "pop lost")

endmodule

`default_nettype wire

// ===== design/ncm_back.sv =====
// search engine: color table, lfsr, distance pipeline and result register
// depends on ncm_pkg and ncm_out_if; takes requests from ncm_queue
`default_nettype none
`include "assert_macros.svh"

module ncm_back #(
  parameter int TABLE_DEPTH = ncm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ncm_pkg::FLOOR_W-1:0] random_floor,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  ncm_pkg::item_t              pop_item,
  ncm_out_if.source                   out_ch
);
  import ncm_pkg::*;

  // slots past the reach of the load index are never valid and never stored
  localparam int PD    = (TABLE_DEPTH < MAX_SLOTS) ? TABLE_DEPTH : MAX_SLOTS;
  localparam int IW    = (PD > 1) ? $clog2(PD) : 1;
  localparam int MAG_W = 13;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int PROD_W = LFSR_W + FLOOR_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic fb;
    fb = v[0] ^ v[2] ^ v[3] ^ v[5];
    return {fb, v[LFSR_W-1:1]};
  endfunction

  function automatic logic [MAG_W-1:0] chan_mag(input logic [CHAN_W-1:0] c,
                                                input logic [CHAN_W-1:0] t,
                                                input logic [FLOOR_W-1:0] dev);
    logic [14:0] diff;
    diff = (({7'b0, c} - {7'b0, t}) << 4) - {3'b0, dev};
    return diff[14] ? MAG_W'(-diff) : MAG_W'(diff);
  endfunction

  state_t              state_r;
  logic [IW-1:0]       walk_idx_r;
  logic [CHAN_W-1:0]   tgt_r [3];
  logic                have_r;
  logic [IW-1:0]       best_idx_r;
  logic [DIST_W-1:0]   best_dist_r;
  logic                out_valid_r;
  logic [INDEX_W-1:0]  out_idx_r;
  logic                out_found_r;
  logic [DIST_W-1:0]   out_dist_r;

  logic [3*CHAN_W-1:0] mem [PD];
  logic [3*CHAN_W-1:0] rd_data_r;
  logic [PD-1:0]       valid_r;
  logic                load_we;

  logic [LFSR_W-1:0]   lfsr_r;
  logic [LFSR_W-1:0]   lfsr_adv;

  logic                s1_pv_r, s2_pv_r, s3_pv_r, s4_pv_r, s5_pv_r;
  logic                s1_ev_r, s2_ev_r, s3_ev_r, s4_ev_r, s5_ev_r;
  logic                s1_last_r, s2_last_r, s3_last_r, s4_last_r, s5_last_r;
  logic [IW-1:0]       s1_idx_r, s2_idx_r, s3_idx_r, s4_idx_r, s5_idx_r;
  logic [PROD_W-1:0]   s2_prod_r;
  logic [3*CHAN_W-1:0] s2_color_r;
  logic [MAG_W-1:0]    s3_mag_r [3];
  logic [SQ_W-1:0]     s4_sq_r [3];
  logic [DIST_W-1:0]   s5_dist_r;
  logic                better;

  assign pop_ready = (state_r == ST_IDLE);
  assign load_we   = pop_valid && (state_r == ST_IDLE) && (pop_item.op == OP_LOAD);
  assign lfsr_adv  = lfsr_step(lfsr_r);
  assign better    = s5_pv_r && s5_ev_r && (!have_r || (s5_dist_r < best_dist_r));

  assign out_ch.valid         = out_valid_r;
  assign out_ch.best_index    = out_idx_r;
  assign out_ch.found         = out_found_r;
  assign out_ch.best_distance = out_dist_r;

  // color store
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[pop_item.idx[IW-1:0]] <= {pop_item.red, pop_item.green, pop_item.blue};
    end
    rd_data_r <= mem[walk_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (load_we) begin
      valid_r[pop_item.idx[IW-1:0]] <= pop_item.valid;
    end
  end

  // distance pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r  <= LFSR_SEED;
      s1_pv_r <= 1'b0;
      s2_pv_r <= 1'b0;
      s3_pv_r <= 1'b0;
      s4_pv_r <= 1'b0;
      s5_pv_r <= 1'b0;
    end else begin
      s1_pv_r <= (state_r == ST_WALK);
      s2_pv_r <= s1_pv_r;
      s3_pv_r <= s2_pv_r;
      s4_pv_r <= s3_pv_r;
      s5_pv_r <= s4_pv_r;
      if (s1_pv_r && s1_ev_r) begin
        lfsr_r <= lfsr_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_ev_r   <= valid_r[walk_idx_r];
    s1_idx_r  <= walk_idx_r;
    s1_last_r <= (walk_idx_r == IW'(PD - 1));

    s2_ev_r    <= s1_ev_r;
    s2_idx_r   <= s1_idx_r;
    s2_last_r  <= s1_last_r;
    s2_color_r <= rd_data_r;
    s2_prod_r  <= {{FLOOR_W{1'b0}}, lfsr_adv} * {{LFSR_W{1'b0}}, random_floor};

    s3_ev_r   <= s2_ev_r;
    s3_idx_r  <= s2_idx_r;
    s3_last_r <= s2_last_r;
    s3_mag_r[0] <= chan_mag(s2_color_r[23:16], tgt_r[0], s2_prod_r[PROD_W-1:LFSR_W]);
    s3_mag_r[1] <= chan_mag(s2_color_r[15:8],  tgt_r[1], s2_prod_r[PROD_W-1:LFSR_W]);
    s3_mag_r[2] <= chan_mag(s2_color_r[7:0],   tgt_r[2], s2_prod_r[PROD_W-1:LFSR_W]);

    s4_ev_r   <= s3_ev_r;
    s4_idx_r  <= s3_idx_r;
    s4_last_r <= s3_last_r;
    for (int k = 0; k < 3; k++) begin
      s4_sq_r[k] <= {{MAG_W{1'b0}}, s3_mag_r[k]} * {{MAG_W{1'b0}}, s3_mag_r[k]};
    end

    s5_ev_r   <= s4_ev_r;
    s5_idx_r  <= s4_idx_r;
    s5_last_r <= s4_last_r;
    s5_dist_r <= {2'b0, s4_sq_r[0]} + {2'b0, s4_sq_r[1]} + {2'b0, s4_sq_r[2]};
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      walk_idx_r  <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      if (better) begin
        have_r      <= 1'b1;
        best_idx_r  <= s5_idx_r;
        best_dist_r <= s5_dist_r;
      end
      case (state_r)
        ST_IDLE: begin
          if (pop_valid && (pop_item.op == OP_QUERY)) begin
            tgt_r[0]    <= pop_item.red;
            tgt_r[1]    <= pop_item.green;
            tgt_r[2]    <= pop_item.blue;
            walk_idx_r  <= '0;
            have_r      <= 1'b0;
            best_idx_r  <= '0;
            best_dist_r <= '0;
            state_r     <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_idx_r == IW'(PD - 1)) begin
            state_r <= ST_DRAIN;
          end else begin
            walk_idx_r <= walk_idx_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (s5_pv_r && s5_last_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= INDEX_W'(best_idx_r);
            out_found_r <= have_r;
            out_dist_r  <= best_dist_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_lfsr_live, clk, rst_n, lfsr_r != '0, "lfsr stuck at zero")
  `ASSERT_IMPLY(a_result_src, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_DONE), "stray result")
  `ASSERT_IMPLY(a_idle_empty, clk, rst_n, state_r == ST_IDLE, !(s1_pv_r || s2_pv_r || s3_pv_r || s4_pv_r || s5_pv_r), "pipeline busy in idle")

endmodule

`default_nettype wire
